// File: rtl/core/sbrc_pkg.sv
`timescale 1ns / 1ps

package sbrc_pkg;

    localparam logic [7:0]  ACK_CODE      = 8'hCC;
    localparam logic [7:0]  NACK_CODE     = 8'h33;
    localparam logic [7:0]  ACK_LEAD      = 8'h00;
    localparam logic [7:0]  HEADER_BYTES  = 8'd2;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    typedef enum logic [1:0] {
        OP_ARM_ACK  = 2'd0,
        OP_ARM_DATA = 2'd1,
        OP_BYTE     = 2'd2,
        OP_TICK     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TIMEOUT  = 2'd1,
        ST_ERROR    = 2'd2,
        ST_CHECKSUM = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_ACK_FIRST  = 3'd1,
        PH_ACK_SECOND = 3'd2,
        PH_LEN        = 3'd3,
        PH_SUM        = 3'd4,
        PH_PAYLOAD    = 3'd5
    } t_phase;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] rx_byte;
        logic [7:0] max_len;
    } t_in_item;

    typedef struct packed {
        logic       is_final;
        logic [7:0] payload_byte;
        logic [1:0] status;
        logic       was_ack;
    } t_out_item;

endpackage

// File: rtl/core/sbrc_in_stage.sv
`timescale 1ns / 1ps

module sbrc_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  sbrc_pkg::t_in_item i_item,
    input  logic              i_step,
    output logic              o_vld,
    output sbrc_pkg::t_in_item o_item
);

    logic               r_vld;
    sbrc_pkg::t_in_item r_item;

    // The register frees up in the same cycle as its transaction is consumed.
    assign o_ready = !r_vld || i_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_vld <= 1'b1;
        end else if (i_step) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

// File: rtl/core/sbrc_engine.sv
`timescale 1ns / 1ps

module sbrc_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata,
    input  logic               i_step,
    input  sbrc_pkg::t_in_item i_item,
    output logic               o_res_valid,
    output sbrc_pkg::t_out_item o_res
);

    sbrc_pkg::t_phase r_phase,  n_phase;
    logic [7:0]       r_first_byte, n_first_byte;
    logic [7:0]       r_expected_sum, n_expected_sum;
    logic [7:0]       r_bytes_left, n_bytes_left;
    logic [7:0]       r_running_sum, n_running_sum;
    logic [15:0]      r_idle_ticks, n_idle_ticks;
    logic [7:0]       r_length_limit, n_length_limit;
    logic [15:0]      r_timeout_ticks;

    logic       w_armed;
    logic [7:0] w_len_minus;
    logic [7:0] w_left_dec;
    logic [7:0] w_sum_add;
    logic       w_timed_out;
    logic       w_too_long;

    assign w_armed     = (r_phase != sbrc_pkg::PH_IDLE);
    assign w_len_minus = i_item.rx_byte - sbrc_pkg::HEADER_BYTES;
    assign w_left_dec  = r_bytes_left - 8'd1;
    assign w_sum_add   = r_running_sum + i_item.rx_byte;
    assign w_timed_out = (r_idle_ticks >= r_timeout_ticks);
    assign w_too_long  = (r_bytes_left > r_length_limit);

    // Next state.
    always_comb begin
        n_phase        = r_phase;
        n_first_byte   = r_first_byte;
        n_expected_sum = r_expected_sum;
        n_bytes_left   = r_bytes_left;
        n_running_sum  = r_running_sum;
        n_idle_ticks   = r_idle_ticks;
        n_length_limit = r_length_limit;
        if (i_step) begin
            unique case (sbrc_pkg::t_op'(i_item.op))
                sbrc_pkg::OP_ARM_ACK, sbrc_pkg::OP_ARM_DATA: begin
                    if (i_item.op == sbrc_pkg::OP_ARM_ACK) begin
                        n_phase = sbrc_pkg::PH_ACK_FIRST;
                    end else begin
                        n_phase        = sbrc_pkg::PH_LEN;
                        n_length_limit = i_item.max_len;
                    end
                    n_first_byte   = 8'd0;
                    n_expected_sum = 8'd0;
                    n_bytes_left   = 8'd0;
                    n_running_sum  = 8'd0;
                    n_idle_ticks   = 16'd0;
                end
                sbrc_pkg::OP_BYTE: begin
                    if (w_armed) begin
                        n_idle_ticks = 16'd0;
                    end
                    unique case (r_phase)
                        sbrc_pkg::PH_ACK_FIRST: begin
                            n_first_byte = i_item.rx_byte;
                            n_phase      = sbrc_pkg::PH_ACK_SECOND;
                        end
                        sbrc_pkg::PH_ACK_SECOND: begin
                            n_phase = sbrc_pkg::PH_IDLE;
                        end
                        sbrc_pkg::PH_LEN: begin
                            n_bytes_left = w_len_minus;
                            n_phase      = sbrc_pkg::PH_SUM;
                        end
                        sbrc_pkg::PH_SUM: begin
                            n_expected_sum = i_item.rx_byte;
                            n_running_sum  = 8'd0;
                            if (w_too_long || r_bytes_left == 8'd0) begin
                                n_phase = sbrc_pkg::PH_IDLE;
                            end else begin
                                n_phase = sbrc_pkg::PH_PAYLOAD;
                            end
                        end
                        sbrc_pkg::PH_PAYLOAD: begin
                            n_running_sum = w_sum_add;
                            n_bytes_left  = w_left_dec;
                            if (w_left_dec == 8'd0) begin
                                n_phase = sbrc_pkg::PH_IDLE;
                            end
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase
                end
                sbrc_pkg::OP_TICK: begin
                    if (w_armed) begin
                        if (w_timed_out) begin
                            n_phase = sbrc_pkg::PH_IDLE;
                        end else begin
                            n_idle_ticks = r_idle_ticks + 16'd1;
                        end
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // Result of the current transaction.
    always_comb begin
        o_res_valid        = 1'b0;
        o_res.is_final     = 1'b1;
        o_res.payload_byte = 8'd0;
        o_res.status       = sbrc_pkg::ST_OK;
        o_res.was_ack      = 1'b0;
        if (i_item.op == sbrc_pkg::OP_BYTE) begin
            unique case (r_phase)
                sbrc_pkg::PH_ACK_SECOND: begin
                    o_res_valid = 1'b1;
                    if (r_first_byte == sbrc_pkg::ACK_LEAD
                        && (i_item.rx_byte == sbrc_pkg::ACK_CODE
                            || i_item.rx_byte == sbrc_pkg::NACK_CODE)) begin
                        o_res.was_ack = (i_item.rx_byte == sbrc_pkg::ACK_CODE);
                    end else begin
                        o_res.status = sbrc_pkg::ST_ERROR;
                    end
                end
                sbrc_pkg::PH_SUM: begin
                    if (w_too_long) begin
                        o_res_valid  = 1'b1;
                        o_res.status = sbrc_pkg::ST_ERROR;
                    end else if (r_bytes_left == 8'd0) begin
                        o_res_valid  = 1'b1;
                        o_res.status = (i_item.rx_byte == 8'd0) ? sbrc_pkg::ST_OK
                                                                : sbrc_pkg::ST_CHECKSUM;
                    end
                end
                sbrc_pkg::PH_PAYLOAD: begin
                    o_res_valid        = 1'b1;
                    o_res.payload_byte = i_item.rx_byte;
                    if (w_left_dec == 8'd0) begin
                        o_res.status = (w_sum_add == r_expected_sum) ? sbrc_pkg::ST_OK
                                                                    : sbrc_pkg::ST_CHECKSUM;
                    end else begin
                        o_res.is_final = 1'b0;
                    end
                end
                default: begin
                    o_res_valid = 1'b0;
                end
            endcase
        end else if (i_item.op == sbrc_pkg::OP_TICK && w_armed && w_timed_out) begin
            o_res_valid  = 1'b1;
            o_res.status = sbrc_pkg::ST_TIMEOUT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= sbrc_pkg::PH_IDLE;
            r_first_byte    <= 8'd0;
            r_expected_sum  <= 8'd0;
            r_bytes_left    <= 8'd0;
            r_running_sum   <= 8'd0;
            r_idle_ticks    <= 16'd0;
            r_length_limit  <= 8'd0;
            r_timeout_ticks <= sbrc_pkg::TIMEOUT_RESET;
        end else begin
            r_phase        <= n_phase;
            r_first_byte   <= n_first_byte;
            r_expected_sum <= n_expected_sum;
            r_bytes_left   <= n_bytes_left;
            r_running_sum  <= n_running_sum;
            r_idle_ticks   <= n_idle_ticks;
            r_length_limit <= n_length_limit;
            if (i_cfg_we) begin
                r_timeout_ticks <= i_cfg_wdata;
            end
        end
    end

endmodule

// File: rtl/core/sbrc_out_stage.sv
`timescale 1ns / 1ps

module sbrc_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_res_valid,
    input  sbrc_pkg::t_out_item i_res,
    output logic                o_slot_free,
    output logic                o_valid,
    input  logic                i_ready,
    output sbrc_pkg::t_out_item o_item
);

    logic                r_vld;
    sbrc_pkg::t_out_item r_item;

    assign o_slot_free = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_step) begin
            r_vld <= i_res_valid;
        end else if (i_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && i_res_valid) begin
            r_item <= i_res;
        end
    end

    assign o_valid = r_vld;
    assign o_item  = r_item;

endmodule

// File: rtl/core/serial_bootloader_response_checker.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                Payload
// input     in         i_in_valid / o_in_ready  i_in_data   (t_in_item)
// result    out        o_out_valid / i_out_ready o_out_data (t_out_item)
// config    in         i_cfg_we                 i_cfg_wdata (timeout ticks)
//
// One transaction is taken every cycle while the output is not stalled. A transaction is
// evaluated from the input register against the checker state once the output slot is
// free, and any result it gives is then registered in the output register.
// Synchronous active-low reset: waits disarmed, timeout back to 1000 ticks.
// A stalled output holds the evaluation, and the input register then fills and
// drops o_in_ready; no clock is lost when the result is taken in the same cycle.

module serial_bootloader_response_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sbrc_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sbrc_pkg::t_out_item o_out_data,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_wdata
);

    logic                w_in_vld;
    sbrc_pkg::t_in_item  w_in_item;
    logic                w_slot_free;
    logic                w_step;
    logic                w_res_valid;
    sbrc_pkg::t_out_item w_res;

    assign w_step = w_in_vld && w_slot_free;

    sbrc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_data),
        .i_step  (w_step),
        .o_vld   (w_in_vld),
        .o_item  (w_in_item)
    );

    sbrc_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (w_step),
        .i_item      (w_in_item),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    sbrc_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .o_slot_free (w_slot_free),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_item      (o_out_data)
    );

    // A transaction waiting in the input register is neither lost nor altered.
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_vld && !w_step |=> w_in_vld && $stable(w_in_item))
        else $error("input transaction lost while stalled");

    // Only a final result can carry a non-zero status or an acknowledge flag.
    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.is_final |->
            o_out_data.status == sbrc_pkg::ST_OK && !o_out_data.was_ack)
        else $error("payload result carries status");

    // Timeouts and protocol errors never carry a payload byte.
    a_error_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == sbrc_pkg::ST_TIMEOUT
                        || o_out_data.status == sbrc_pkg::ST_ERROR) |->
            o_out_data.payload_byte == 8'd0 && !o_out_data.was_ack)
        else $error("error result carries data");

endmodule

// File: dv/serial_bootloader_response_checker_test.sv
`timescale 1ns / 1ps

module serial_bootloader_response_checker_test;

    localparam int RX_ALWAYS  = 0;
    localparam int RX_RANDOM  = 1;
    localparam int RX_PATTERN = 2;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    sbrc_pkg::t_in_item  i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    sbrc_pkg::t_out_item o_out_data;
    logic                i_cfg_we    = 1'b0;
    logic [15:0]         i_cfg_wdata = '0;

    serial_bootloader_response_checker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Shadow of the link checker state, advanced once per accepted transaction.
    sbrc_pkg::t_phase link_phase   = sbrc_pkg::PH_IDLE;
    logic [7:0]       link_first   = '0;
    logic [7:0]       link_check   = '0;
    logic [7:0]       link_left    = '0;
    logic [7:0]       link_sum     = '0;
    logic [7:0]       link_limit   = '0;
    logic [15:0]      link_idle    = '0;
    logic [15:0]      link_timeout = sbrc_pkg::TIMEOUT_RESET;

    sbrc_pkg::t_out_item expected_replies[$];

    int errors          = 0;
    int checked_results = 0;
    int sent_items      = 0;
    int settings_used   = 0;
    bit gaps_on         = 1'b1;
    int burst_left      = 0;
    int ready_mode      = RX_RANDOM;
    int stall_count     = 0;

    function automatic sbrc_pkg::t_in_item link_item(input sbrc_pkg::t_op op,
                                                     input logic [7:0] b,
                                                     input logic [7:0] ml);
        sbrc_pkg::t_in_item it;
        it.op      = op;
        it.rx_byte = b;
        it.max_len = ml;
        return it;
    endfunction

    task automatic post_reply(input logic fin, input logic [7:0] pb,
                              input sbrc_pkg::t_status st, input logic ack);
        sbrc_pkg::t_out_item r;
        r.is_final     = fin;
        r.payload_byte = pb;
        r.status       = st;
        r.was_ack      = ack;
        expected_replies.push_back(r);
        if (fin)
            link_phase = sbrc_pkg::PH_IDLE;
    endtask

    task automatic predict_link(input sbrc_pkg::t_in_item it);
        bit armed;
        logic [7:0] b;
        armed = (link_phase != sbrc_pkg::PH_IDLE);
        b = it.rx_byte;
        case (it.op)
            sbrc_pkg::OP_ARM_ACK, sbrc_pkg::OP_ARM_DATA: begin
                link_phase = (it.op == sbrc_pkg::OP_ARM_ACK) ? sbrc_pkg::PH_ACK_FIRST
                                                            : sbrc_pkg::PH_LEN;
                if (it.op == sbrc_pkg::OP_ARM_DATA)
                    link_limit = it.max_len;
                link_first = '0;
                link_check = '0;
                link_left  = '0;
                link_sum   = '0;
                link_idle  = '0;
            end
            sbrc_pkg::OP_BYTE: if (armed) begin
                link_idle = '0;
                case (link_phase)
                    sbrc_pkg::PH_ACK_FIRST: begin
                        link_first = b;
                        link_phase = sbrc_pkg::PH_ACK_SECOND;
                    end
                    sbrc_pkg::PH_ACK_SECOND: begin
                        if (link_first == sbrc_pkg::ACK_LEAD
                            && (b == sbrc_pkg::ACK_CODE || b == sbrc_pkg::NACK_CODE))
                            post_reply(1'b1, 8'd0, sbrc_pkg::ST_OK, b == sbrc_pkg::ACK_CODE);
                        else
                            post_reply(1'b1, 8'd0, sbrc_pkg::ST_ERROR, 1'b0);
                    end
                    sbrc_pkg::PH_LEN: begin
                        link_left  = b - sbrc_pkg::HEADER_BYTES;
                        link_phase = sbrc_pkg::PH_SUM;
                    end
                    sbrc_pkg::PH_SUM: begin
                        link_check = b;
                        link_sum   = '0;
                        if (link_left > link_limit)
                            post_reply(1'b1, 8'd0, sbrc_pkg::ST_ERROR, 1'b0);
                        else if (link_left == 8'd0)
                            post_reply(1'b1, 8'd0, (link_check == 8'd0) ? sbrc_pkg::ST_OK
                                                                      : sbrc_pkg::ST_CHECKSUM,
                                       1'b0);
                        else
                            link_phase = sbrc_pkg::PH_PAYLOAD;
                    end
                    sbrc_pkg::PH_PAYLOAD: begin
                        link_sum  = link_sum + b;
                        link_left = link_left - 8'd1;
                        if (link_left == 8'd0)
                            post_reply(1'b1, b, (link_sum == link_check) ? sbrc_pkg::ST_OK
                                                                       : sbrc_pkg::ST_CHECKSUM,
                                       1'b0);
                        else
                            post_reply(1'b0, b, sbrc_pkg::ST_OK, 1'b0);
                    end
                    default: ;
                endcase
            end
            default: if (armed) begin
                if (link_idle >= link_timeout)
                    post_reply(1'b1, 8'd0, sbrc_pkg::ST_TIMEOUT, 1'b0);
                else
                    link_idle = link_idle + 16'd1;
            end
        endcase
    endtask

    // Sender: bursts of back-to-back transactions separated by random gaps.
    task automatic send_item(input sbrc_pkg::t_in_item it);
        int gap;
        @(negedge i_clk);
        if (gaps_on && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sent_items++;
        predict_link(it);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(link_item(sbrc_pkg::OP_BYTE, b, 8'($urandom)));
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(link_item(sbrc_pkg::OP_TICK, 8'($urandom), 8'($urandom)));
    endtask

    task automatic arm_ack();
        send_item(link_item(sbrc_pkg::OP_ARM_ACK, 8'($urandom), 8'($urandom)));
    endtask

    task automatic arm_data(input logic [7:0] ml);
        send_item(link_item(sbrc_pkg::OP_ARM_DATA, 8'($urandom), ml));
    endtask

    // Stop sending and let every outstanding result drain, plus the pipeline depth,
    // since a transaction that gives no result may still be in flight.
    task automatic settle_link();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_timeout(input logic [15:0] ticks);
        settle_link();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= ticks;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        link_timeout = ticks;
        settings_used++;
    endtask

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        sbrc_pkg::t_out_item want;
        sbrc_pkg::t_out_item got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = o_out_data;
            if (expected_replies.size() == 0) begin
                $display("%0t ns: result with none expected, expected nothing, got %p",
                         $time, got);
                errors++;
            end else begin
                want = expected_replies.pop_front();
                check_field("is_final", 8'(want.is_final), 8'(got.is_final));
                check_field("payload_byte", want.payload_byte, got.payload_byte);
                check_field("status", 8'(want.status), 8'(got.status));
                check_field("was_ack", 8'(want.was_ack), 8'(got.was_ack));
                checked_results++;
            end
        end
    end

    always @(negedge i_clk) begin
        stall_count <= stall_count + 1;
        case (ready_mode)
            RX_ALWAYS: i_out_ready <= 1'b1;
            RX_RANDOM: i_out_ready <= ($urandom_range(0, 9) >= 3);
            default:   i_out_ready <= ((stall_count % 13) > 4);
        endcase
    end

    task automatic test_ack_waits();
        send_byte(8'hFF);
        send_ticks(1);
        arm_ack();
        send_byte(sbrc_pkg::ACK_LEAD);
        send_byte(sbrc_pkg::ACK_CODE);
        arm_ack();
        send_byte(sbrc_pkg::ACK_LEAD);
        send_byte(sbrc_pkg::NACK_CODE);
        // Re-arming as a data wait drops the half-finished acknowledge wait.
        arm_ack();
        send_byte(sbrc_pkg::ACK_LEAD);
        arm_data(8'hFF);
        send_byte(8'd2);
        send_byte(8'd0);
    endtask

    task automatic test_data_waits();
        arm_data(8'd0);
        send_byte(8'd2);
        send_byte(8'hFF);
        // A length byte of zero wraps to a payload of 254, above the limit.
        arm_data(8'd200);
        send_byte(8'd0);
        send_byte(8'd0);
        // The last payload byte breaks the sum and still travels in the final result.
        arm_data(8'd3);
        send_byte(8'd5);
        send_byte(8'h10);
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(8'h0F);
    endtask

    task automatic test_timeouts();
        gaps_on = 1'b0;
        arm_ack();
        send_ticks(int'(sbrc_pkg::TIMEOUT_RESET) + 1);
        gaps_on = 1'b1;
        set_timeout(16'd0);
        arm_data(8'd9);
        send_ticks(1);
        set_timeout(16'd3);
        arm_ack();
        send_ticks(3);
        send_byte(sbrc_pkg::ACK_LEAD);
        send_ticks(4);
        set_timeout(16'hFFFF);
        arm_data(8'd4);
        send_ticks(5);
    endtask

    task automatic idle_ticks_maybe();
        if ($urandom_range(0, 3) == 0) begin
            if (link_timeout <= 16'd8)
                send_ticks($urandom_range(0, int'(link_timeout) + 2));
            else
                send_ticks($urandom_range(1, 4));
        end
    endtask

    task automatic random_ack_wait();
        int r;
        arm_ack();
        idle_ticks_maybe();
        if (link_phase != sbrc_pkg::PH_ACK_FIRST)
            return;
        send_byte(($urandom_range(0, 9) == 0) ? 8'($urandom) : sbrc_pkg::ACK_LEAD);
        if ($urandom_range(0, 19) == 0)
            return;
        idle_ticks_maybe();
        if (link_phase != sbrc_pkg::PH_ACK_SECOND)
            return;
        r = $urandom_range(0, 9);
        send_byte((r < 4) ? sbrc_pkg::ACK_CODE
                          : (r < 8) ? sbrc_pkg::NACK_CODE : 8'($urandom));
    endtask

    task automatic random_data_wait();
        int r;
        int plen;
        logic [7:0] sum;
        logic [7:0] body[$];
        r = $urandom_range(0, 99);
        if (r < 80)
            plen = $urandom_range(0, 10);
        else if (r < 96)
            plen = $urandom_range(11, 60);
        else
            plen = $urandom_range(61, 255);
        arm_data(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(plen, 255)));
        sum = '0;
        for (int i = 0; i < plen; i++) begin
            body.push_back(8'($urandom));
            sum += body[i];
        end
        idle_ticks_maybe();
        send_byte(($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'(plen + 2));
        idle_ticks_maybe();
        send_byte(($urandom_range(0, 7) == 0) ? 8'($urandom) : sum);
        foreach (body[i]) begin
            if (link_phase != sbrc_pkg::PH_PAYLOAD || $urandom_range(0, 59) == 0)
                break;
            idle_ticks_maybe();
            if (link_phase != sbrc_pkg::PH_PAYLOAD)
                break;
            send_byte(body[i]);
        end
    endtask

    task automatic test_random_traffic();
        int seq;
        int pick;
        seq = 0;
        while (sent_items < 1800) begin
            if (seq % 20 == 0) begin
                case ((seq / 20) % 6)
                    0:       set_timeout(16'd0);
                    1:       set_timeout(16'($urandom_range(1, 8)));
                    2:       set_timeout(16'hFFFF);
                    3:       set_timeout(sbrc_pkg::TIMEOUT_RESET);
                    4:       set_timeout(16'($urandom_range(0, 65535)));
                    default: set_timeout(16'($urandom_range(2, 5)));
                endcase
                gaps_on    = ($urandom_range(0, 3) != 0);
                ready_mode = $urandom_range(RX_ALWAYS, RX_PATTERN);
            end
            pick = $urandom_range(0, 99);
            if (pick < 40)
                random_ack_wait();
            else if (pick < 85)
                random_data_wait();
            else
                repeat ($urandom_range(1, 3))
                    send_item(link_item(sbrc_pkg::t_op'($urandom_range(0, 3)),
                                        8'($urandom), 8'($urandom)));
            if ($urandom_range(0, 39) == 0)
                settle_link();
            seq++;
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_ack_waits();
        test_data_waits();
        test_timeouts();
        test_random_traffic();
        settle_link();

        $display("Ack and data waits, re-arming, length refusal, checksums and timeouts");
        $display("across %0d timeout settings: %0d transactions, %0d results checked.",
                 settings_used, sent_items, checked_results);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Run timed out with %0d results outstanding.", expected_replies.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: files.f
rtl/core/sbrc_pkg.sv
rtl/core/sbrc_in_stage.sv
rtl/core/sbrc_engine.sv
rtl/core/sbrc_out_stage.sv
rtl/core/serial_bootloader_response_checker.sv
dv/serial_bootloader_response_checker_test.sv
